// ----- rtl/core/bba_pkg.sv -----
// shared types, constants and control structs of the buddy allocator
package bba_pkg;

    // default geometry
    localparam int MIN_BYTES_DEF = 8;
    localparam int LEVELS_DEF    = 9;
    localparam int TOP_RESET     = 8;

    // fixed field widths
    localparam int TOP_W    = 4;
    localparam int REQ_W    = 12;
    localparam int GRANT_W  = 11;
    localparam int STATUS_W = 2;

    // free-map memory word: one bit per block, several blocks per row
    localparam int WORD_SHIFT = 4;
    localparam int WORD_BITS  = 1 << WORD_SHIFT;

    // action codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_BAD_ADDR  = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic take;        // latch request, size level and range check
        logic prep;        // free address check and first block index
        logic rd;          // read free-map row of current level and block
        logic grab;        // take lowest free block of read row
        logic split_step;  // go one level down, block index doubles
        logic set_buddy;   // mark upper half free after a split
        logic scan_next;   // next row of the same level
        logic level_up;    // search one level higher
        logic no_space;    // record that no block was found
        logic merge;       // clear free buddy and climb one level
        logic set_own;     // mark the freed (merged) block free
        logic load_out;    // move the result into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic too_large;
        logic bad_free;
        logic is_free;
        logic hit;
        logic last_row;
        logic at_top;
        logic at_want;
        logic buddy_free;
        logic out_free;
    } t_stat;

endpackage

// ----- rtl/core/bba_ifs.sv -----
// valid/ready channel interfaces of the buddy allocator
interface bba_req_if import bba_pkg::*;;
    logic             valid;
    logic             ready;
    logic             action;
    logic [REQ_W-1:0] request_bytes;
    logic [REQ_W-1:0] block_offset;

    modport source (output valid, output action, output request_bytes,
                    output block_offset, input ready);
    modport sink   (input valid, input action, input request_bytes,
                    input block_offset, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*;;
    logic                valid;
    logic                ready;
    logic [GRANT_W-1:0]  granted_offset;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output granted_offset, output status, input ready);
    modport sink   (input valid, input granted_offset, input status, output ready);
endinterface

interface bba_cfg_if import bba_pkg::*;;
    logic             valid;
    logic             ready;
    logic [TOP_W-1:0] top_level;

    modport source (output valid, output top_level, input ready);
    modport sink   (input valid, input top_level, output ready);
endinterface

// ----- rtl/core/bba_ctrl.sv -----
// sequencing state machine of the buddy allocator
module bba_ctrl import bba_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_req_valid,
    output logic  o_req_ready,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_SRD,
        S_SEV,
        S_STEP,
        S_PRD,
        S_PEV,
        S_MRD,
        S_MEV,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                if (i_stat.too_large || i_stat.bad_free) begin
                    n_state = S_DONE;
                end else if (i_stat.is_free) begin
                    n_state = S_MRD;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_SRD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_SEV;
            end
            S_SEV: begin
                if (i_stat.hit) begin
                    o_cmd.grab = 1'b1;
                    n_state    = i_stat.at_want ? S_DONE : S_STEP;
                end else if (!i_stat.last_row) begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = S_SRD;
                end else if (i_stat.at_top) begin
                    o_cmd.no_space = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.level_up = 1'b1;
                    n_state        = S_SRD;
                end
            end
            S_STEP: begin
                o_cmd.split_step = 1'b1;
                n_state          = S_PRD;
            end
            S_PRD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_PEV;
            end
            S_PEV: begin
                o_cmd.set_buddy = 1'b1;
                n_state         = i_stat.at_want ? S_DONE : S_STEP;
            end
            S_MRD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_MEV;
            end
            S_MEV: begin
                if (!i_stat.at_top && i_stat.buddy_free) begin
                    o_cmd.merge = 1'b1;
                    n_state     = S_MRD;
                end else begin
                    o_cmd.set_own = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/core/bba_dpath.sv -----
// free-map memory, block/level registers and result register of the buddy allocator
module bba_dpath import bba_pkg::*; #(
    parameter int MIN_BLOCK_BYTES = MIN_BYTES_DEF,
    parameter int LEVEL_COUNT     = LEVELS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic                i_cfg_valid,
    input  logic [TOP_W-1:0]    i_cfg_top_level,
    input  logic                i_action,
    input  logic [REQ_W-1:0]    i_request_bytes,
    input  logic [REQ_W-1:0]    i_block_offset,
    output logic                o_rsp_valid,
    input  logic                i_rsp_ready,
    output logic [GRANT_W-1:0]  o_granted_offset,
    output logic [STATUS_W-1:0] o_status
);

    localparam int LW   = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
    localparam int BW   = (LEVEL_COUNT > 1) ? LEVEL_COUNT - 1 : 1;
    localparam int S    = WORD_SHIFT;
    localparam int W    = WORD_BITS;
    localparam int PW   = $clog2(MIN_BLOCK_BYTES + 1) + LEVEL_COUNT;
    localparam int XW   = (PW > REQ_W + 1) ? PW : REQ_W + 1;
    localparam int CW0  = (BW + 1 > S + 1) ? BW + 1 : S + 1;
    localparam int CW   = CW0 + 1;
    localparam int TOP_INIT = (TOP_RESET > LEVEL_COUNT - 1) ? LEVEL_COUNT - 1 : TOP_RESET;

    function automatic int f_level_rows(int lv);
        return (LEVEL_COUNT - 1 - lv >= S) ? (1 << (LEVEL_COUNT - 1 - lv - S)) : 1;
    endfunction

    function automatic int f_total_rows();
        int acc;
        acc = 0;
        for (int lv = 0; lv < LEVEL_COUNT; lv++) begin
            acc += f_level_rows(lv);
        end
        return acc;
    endfunction

    localparam int ROWS = f_total_rows();
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    function automatic logic [LEVEL_COUNT-1:0][RW-1:0] f_bases();
        logic [LEVEL_COUNT-1:0][RW-1:0] b;
        int acc;
        acc = 0;
        for (int lv = 0; lv < LEVEL_COUNT; lv++) begin
            b[lv] = RW'(acc);
            acc  += f_level_rows(lv);
        end
        return b;
    endfunction

    localparam logic [LEVEL_COUNT-1:0][RW-1:0] ROW_BASE = f_bases();

    // config and request registers
    logic [LW-1:0]      r_top;
    logic               r_act;
    logic [REQ_W-1:0]   r_offset;
    logic [LW-1:0]      r_lv;
    logic [LW-1:0]      r_want;
    logic [BW-1:0]      r_blk;
    t_status            r_status;

    // free-map storage
    logic [W-1:0]       r_mem [ROWS];
    logic [ROWS-1:0]    r_row_vld;
    logic [W-1:0]       r_rdata;
    logic               r_rd_vld;
    logic               r_rd_top;

    // result register
    logic               r_rsp_valid;
    logic [GRANT_W-1:0] r_granted;
    t_status            r_rsp_status;

    logic [XW-1:0]      pool;
    logic [XW-1:0]      req_x;
    logic [LW-1:0]      want_lv;
    logic [XW-1:0]      off_x;
    logic [XW-1:0]      sh_x;
    logic [XW-1:0]      low_mask;
    logic [XW-1:0]      blk_q;
    logic [XW-1:0]      blk_r;
    logic               bad_free;
    logic [W-1:0]       word;
    logic [S-1:0]       hit_idx;
    logic [S-1:0]       bit_idx;
    logic [S-1:0]       buddy_idx;
    logic [CW-1:0]      lvl_count;
    logic [RW-1:0]      row;
    logic               wr_en;
    logic [W-1:0]       wr_data;
    logic [XW-1:0]      grant_x;

    assign pool  = XW'(MIN_BLOCK_BYTES) << r_top;
    assign req_x = XW'(i_request_bytes);

    // smallest level whose block holds the request
    always_comb begin
        want_lv = '0;
        for (int lv = LEVEL_COUNT - 1; lv >= 0; lv--) begin
            if (req_x <= (XW'(MIN_BLOCK_BYTES) << lv)) begin
                want_lv = LW'(lv);
            end
        end
    end

    // free address: inside pool and aligned to its block size
    assign off_x    = XW'(r_offset);
    assign sh_x     = off_x >> r_want;
    assign low_mask = (XW'(1) << r_want) - XW'(1);
    assign blk_q    = sh_x / XW'(MIN_BLOCK_BYTES);
    assign blk_r    = sh_x % XW'(MIN_BLOCK_BYTES);
    assign bad_free = (off_x >= pool) || ((off_x & low_mask) != '0) || (blk_r != '0);

    // a row never written reads as after pool init: only the top block free
    assign word = r_rd_vld ? r_rdata : W'(r_rd_top);

    always_comb begin
        hit_idx = '0;
        for (int i = W - 1; i >= 0; i--) begin
            if (word[i]) begin
                hit_idx = S'(i);
            end
        end
    end

    assign bit_idx   = S'(r_blk);
    assign buddy_idx = bit_idx ^ S'(1);
    assign lvl_count = CW'(1) << (r_top - r_lv);
    assign row       = ROW_BASE[r_lv] + RW'(r_blk >> S);

    assign wr_en = i_cmd.grab | i_cmd.set_buddy | i_cmd.merge | i_cmd.set_own;

    always_comb begin
        wr_data = word;
        if (i_cmd.grab) begin
            wr_data = word & ~(W'(1) << hit_idx);
        end else if (i_cmd.set_buddy) begin
            wr_data = word | (W'(1) << buddy_idx);
        end else if (i_cmd.merge) begin
            wr_data = word & ~(W'(1) << buddy_idx);
        end else if (i_cmd.set_own) begin
            wr_data = word | (W'(1) << bit_idx);
        end
    end

    assign grant_x = (XW'(r_blk) << r_want) * XW'(MIN_BLOCK_BYTES);

    always_comb begin
        o_stat            = '0;
        o_stat.too_large  = (r_status == ST_TOO_LARGE);
        o_stat.bad_free   = (r_act == ACT_FREE) && bad_free;
        o_stat.is_free    = (r_act == ACT_FREE);
        o_stat.hit        = |word;
        o_stat.last_row   = (CW'(r_blk) + CW'(W)) >= lvl_count;
        o_stat.at_top     = (r_lv == r_top);
        o_stat.at_want    = (r_lv == r_want);
        o_stat.buddy_free = word[buddy_idx];
        o_stat.out_free   = !r_rsp_valid || i_rsp_ready;
    end

    // memory port: one write or one read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[row] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rdata  <= r_mem[row];
            r_rd_vld <= r_row_vld[row];
            r_rd_top <= (row == ROW_BASE[r_top]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top     <= LW'(TOP_INIT);
            r_row_vld <= '0;
        end else if (i_cfg_valid) begin
            r_top     <= (int'(i_cfg_top_level) > LEVEL_COUNT - 1) ?
                         LW'(LEVEL_COUNT - 1) : LW'(i_cfg_top_level);
            r_row_vld <= '0;
        end else if (wr_en) begin
            r_row_vld[row] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_act    <= i_action;
            r_offset <= i_block_offset;
            r_want   <= want_lv;
            r_lv     <= want_lv;
            r_status <= (req_x > pool) ? ST_TOO_LARGE : ST_OK;
        end
        if (i_cmd.prep) begin
            r_blk <= (r_act == ACT_FREE) ? BW'(blk_q) : '0;
            if (r_status == ST_OK && r_act == ACT_FREE && bad_free) begin
                r_status <= ST_BAD_ADDR;
            end
        end
        if (i_cmd.grab) begin
            r_blk <= r_blk + BW'(hit_idx);
        end
        if (i_cmd.split_step) begin
            r_lv  <= r_lv - LW'(1);
            r_blk <= r_blk << 1;
        end
        if (i_cmd.scan_next) begin
            r_blk <= r_blk + BW'(W);
        end
        if (i_cmd.level_up) begin
            r_lv  <= r_lv + LW'(1);
            r_blk <= '0;
        end
        if (i_cmd.merge) begin
            r_lv  <= r_lv + LW'(1);
            r_blk <= r_blk >> 1;
        end
        if (i_cmd.no_space) begin
            r_status <= ST_NO_SPACE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_rsp_status <= r_status;
            r_granted    <= (r_act == ACT_ALLOC && r_status == ST_OK) ?
                            GRANT_W'(grant_x) : '0;
        end
    end

    assign o_rsp_valid      = r_rsp_valid;
    assign o_granted_offset = r_granted;
    assign o_status         = r_rsp_status;

endmodule

// ----- rtl/core/buddy_block_allocator_unit.sv -----
// top level of the binary buddy allocator
// Binary buddy allocator over a pool of MIN_BLOCK_BYTES << top_level bytes, one request
// beat in and one response beat out per request. The free map keeps one bit per block of
// every level in a single-port memory of 16-bit rows (35 rows at default geometry); a row
// never written since reset or since the last top_level write reads as the freshly
// initialized pool, so no clearing pass is needed and a top_level write takes effect at
// once. A request is taken, checked, then walks the memory row by row, each row access a
// read followed by an evaluate-and-write-back step: a free climbs one level per access
// while its buddy is free, then marks its merged block free; an allocate scans rows upward
// while searching (16 rows at level 0 down to 1 row for the upper levels), then splits
// back down with a step, a read and a write-back per level. Refused requests (too large,
// bad free address) skip the walk. A finished response sits in an output register, so the
// next request is taken while the previous response waits.
module buddy_block_allocator_unit import bba_pkg::*; #(
    parameter int MIN_BLOCK_BYTES = MIN_BYTES_DEF,
    parameter int LEVEL_COUNT     = LEVELS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bba_cfg_if.sink   i_cfg,
    bba_req_if.sink   i_req,
    bba_rsp_if.source o_rsp
);

    t_cmd  cmd;
    t_stat stat;
    logic  req_ready;

    // top_level writes are taken at any time, the pool re-inits in that cycle
    assign i_cfg.ready = 1'b1;
    assign i_req.ready = req_ready;

    // sequencer: search, split and merge steps
    bba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // free-map memory, level/block registers, response register
    bba_dpath #(
        .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
        .LEVEL_COUNT     (LEVEL_COUNT)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_valid      (i_cfg.valid),
        .i_cfg_top_level  (i_cfg.top_level),
        .i_action         (i_req.action),
        .i_request_bytes  (i_req.request_bytes),
        .i_block_offset   (i_req.block_offset),
        .o_rsp_valid      (o_rsp.valid),
        .i_rsp_ready      (o_rsp.ready),
        .o_granted_offset (o_rsp.granted_offset),
        .o_status         (o_rsp.status)
    );

endmodule

// ----- tb/tb.sv -----
// self-checking testbench of the buddy block allocator unit
`timescale 1ns / 100ps

module tb import bba_pkg::*;;

    localparam int MIN_B      = MIN_BYTES_DEF;
    localparam int LEVEL_N    = LEVELS_DEF;
    localparam int MAP_NODES  = (1 << LEVEL_N) - 1;
    localparam int SETTLE_CYC = 16;     // idle cycles before a register write and at the end
    localparam int HOLD_CYC   = 400;    // long response hold-off, fills the block up
    localparam int RAND_ITEMS = 242;    // per top_level setting, six settings

    // one request beat, plus a fixed answer for the rows that carry one
    typedef struct packed {
        logic             act;
        logic [REQ_W-1:0] bytes;
        logic [REQ_W-1:0] offs;
        logic             typed;
        logic [GRANT_W-1:0] grant;
        t_status          status;
    } t_row;

    typedef struct packed {
        logic [GRANT_W-1:0] grant;
        t_status            status;
    } t_answer;

    // a block the stimulus believes it owns
    typedef struct packed {
        logic [REQ_W-1:0] offs;
        logic [REQ_W-1:0] bytes;
    } t_held;

    // directed rows, all at the reset pool of 2048 bytes
    localparam int PLAN_LEN = 21;
    localparam t_row PLAN [PLAN_LEN] = '{
        // zero-byte allocate takes one minimum block at the bottom of the pool
        '{ACT_ALLOC, 12'd0,    12'd0,    1'b1, 11'd0, ST_OK},
        // too large for the pool, alloc and free alike
        '{ACT_ALLOC, 12'd4095, 12'd4095, 1'b1, 11'd0, ST_TOO_LARGE},
        '{ACT_FREE,  12'd4095, 12'd0,    1'b1, 11'd0, ST_TOO_LARGE},
        '{ACT_ALLOC, 12'd2049, 12'd0,    1'b1, 11'd0, ST_TOO_LARGE},
        // free outside the pool, misaligned free
        '{ACT_FREE,  12'd8,    12'd2048, 1'b1, 11'd0, ST_BAD_ADDR},
        '{ACT_FREE,  12'd16,   12'd8,    1'b1, 11'd0, ST_BAD_ADDR},
        '{ACT_FREE,  12'd0,    12'd4095, 1'b1, 11'd0, ST_BAD_ADDR},
        '{ACT_ALLOC, 12'd1,    12'd0,    1'b0, 11'd0, ST_OK},
        '{ACT_ALLOC, 12'd9,    12'd0,    1'b0, 11'd0, ST_OK},
        // whole pool wanted while pieces are out
        '{ACT_ALLOC, 12'd2048, 12'd0,    1'b1, 11'd0, ST_NO_SPACE},
        '{ACT_ALLOC, 12'd1024, 12'hABC,  1'b0, 11'd0, ST_OK},
        // give everything back, merging up to the top
        '{ACT_FREE,  12'd8,    12'd0,    1'b0, 11'd0, ST_OK},
        '{ACT_FREE,  12'd1,    12'd8,    1'b0, 11'd0, ST_OK},
        '{ACT_FREE,  12'd9,    12'd16,   1'b0, 11'd0, ST_OK},
        '{ACT_FREE,  12'd1024, 12'd1024, 1'b0, 11'd0, ST_OK},
        '{ACT_ALLOC, 12'd2048, 12'd0,    1'b0, 11'd0, ST_OK},
        '{ACT_FREE,  12'd2048, 12'd0,    1'b0, 11'd0, ST_OK},
        // double frees go through undetected
        '{ACT_FREE,  12'd8,    12'd0,    1'b0, 11'd0, ST_OK},
        '{ACT_ALLOC, 12'd8,    12'd0,    1'b0, 11'd0, ST_OK},
        '{ACT_FREE,  12'd8,    12'd2040, 1'b0, 11'd0, ST_OK},
        '{ACT_FREE,  12'd2048, 12'd0,    1'b0, 11'd0, ST_OK}
    };

    logic clk;
    logic rst_n;

    bba_cfg_if cfg_bus ();
    bba_req_if req_bus ();
    bba_rsp_if rsp_bus ();

    buddy_block_allocator_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_bus.sink),
        .i_req   (req_bus.sink),
        .o_rsp   (rsp_bus.source)
    );

    // shadow allocator state
    bit          free_bits [MAP_NODES];
    int unsigned pool_top;

    t_answer alloc_answers [$];     // responses owed by the block, oldest first
    t_held   held_blocks   [$];     // blocks handed out and not yet given back
    t_held   recent_frees  [$];     // a few blocks just given back, for double frees
    int      mismatches;
    bit      hold_rsp;              // asks the response side for one long hold-off

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // heap order: root of the largest tree is node 0
    function automatic int unsigned node_idx(int unsigned lv, int unsigned blk);
        return ((1 << (LEVEL_N - 1 - lv)) - 1) + blk;
    endfunction

    function automatic int unsigned pool_bytes();
        return MIN_B << pool_top;
    endfunction

    // a top_level write restarts the pool as one free block
    function automatic void pool_init(logic [TOP_W-1:0] v);
        pool_top = (v > LEVEL_N - 1) ? LEVEL_N - 1 : v;
        foreach (free_bits[i]) free_bits[i] = 1'b0;
        free_bits[node_idx(pool_top, 0)] = 1'b1;
    endfunction

    // level whose block size covers the request, capped at the pool
    function automatic int unsigned size_level(int unsigned bytes);
        int unsigned size;
        int unsigned lv;
        size = MIN_B;
        lv   = 0;
        while (size < bytes && lv < pool_top) begin
            size = size << 1;
            lv++;
        end
        return lv;
    endfunction

    // runs one request on the shadow state and returns the response it owes
    function automatic t_answer buddy_predict(logic act, logic [REQ_W-1:0] bytes,
                                              logic [REQ_W-1:0] offs);
        t_answer     ans;
        int unsigned want;
        int unsigned lv;
        int unsigned blk;
        int unsigned span;
        int unsigned bsize;
        bit          found;
        ans.grant  = '0;
        ans.status = ST_OK;
        found      = 1'b0;
        blk        = 0;
        if (bytes > pool_bytes()) begin
            ans.status = ST_TOO_LARGE;
        end else if (act == ACT_ALLOC) begin
            // search upward for the lowest level with a free block, lowest address first
            want = size_level(bytes);
            lv   = want;
            while (!found && lv <= pool_top) begin
                span = 1 << (pool_top - lv);
                for (int unsigned b = 0; b < span && !found; b++) begin
                    if (free_bits[node_idx(lv, b)]) begin
                        found = 1'b1;
                        blk   = b;
                    end
                end
                if (!found) lv++;
            end
            if (!found) begin
                ans.status = ST_NO_SPACE;
            end else begin
                // split down, the upper half of each split goes free
                free_bits[node_idx(lv, blk)] = 1'b0;
                while (lv > want) begin
                    lv--;
                    blk = blk << 1;
                    free_bits[node_idx(lv, blk + 1)] = 1'b1;
                end
                ans.grant = GRANT_W'((blk * MIN_B) << want);
            end
        end else begin
            lv    = size_level(bytes);
            bsize = MIN_B << lv;
            if (offs >= pool_bytes() || (offs % bsize) != 0) begin
                ans.status = ST_BAD_ADDR;
            end else begin
                // merge with free buddies on the way up
                blk = offs / bsize;
                while (lv < pool_top && free_bits[node_idx(lv, blk ^ 1)]) begin
                    free_bits[node_idx(lv, blk ^ 1)] = 1'b0;
                    blk = blk >> 1;
                    lv++;
                end
                free_bits[node_idx(lv, blk)] = 1'b1;
            end
        end
        return ans;
    endfunction

    task automatic flag_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // a request size that lands exactly on level lv
    function automatic logic [REQ_W-1:0] bytes_in_level(int unsigned lv);
        if (lv == 0) return REQ_W'($urandom_range(0, MIN_B));
        return REQ_W'($urandom_range((MIN_B / 2 << lv) + 1, MIN_B << lv));
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offers one request beat and books the response it owes at acceptance
    task automatic offer_req(t_row row);
        t_answer ans;
        t_held   blk;
        req_bus.valid         <= 1'b1;
        req_bus.action        <= row.act;
        req_bus.request_bytes <= row.bytes;
        req_bus.block_offset  <= row.offs;
        do @(posedge clk); while (!req_bus.ready);
        ans = buddy_predict(row.act, row.bytes, row.offs);
        if (row.typed) begin
            ans.grant  = row.grant;
            ans.status = row.status;
        end
        alloc_answers.push_back(ans);
        if (row.act == ACT_ALLOC && ans.status == ST_OK) begin
            blk.offs  = REQ_W'(ans.grant);
            blk.bytes = row.bytes;
            held_blocks.push_back(blk);
        end
    endtask

    task automatic req_gap(int unsigned n);
        if (n != 0) begin
            req_bus.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain_answers();
        while (alloc_answers.size() != 0) @(posedge clk);
    endtask

    // register write, only with the block idle
    task automatic write_top(logic [TOP_W-1:0] v);
        req_bus.valid <= 1'b0;
        drain_answers();
        repeat (SETTLE_CYC) @(posedge clk);
        cfg_bus.valid     <= 1'b1;
        cfg_bus.top_level <= v;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        pool_init(v);
        held_blocks.delete();
        recent_frees.delete();
    endtask

    // random request: mostly alloc/free traffic on real blocks, the rest noise
    task automatic pick_req(output t_row row);
        int unsigned k;
        int unsigned lv;
        int unsigned pool;
        t_held       blk;
        pool      = pool_bytes();
        row.typed = 1'b0;
        row.grant = '0;
        row.status = ST_OK;
        row.offs  = REQ_W'($urandom);
        if ($urandom_range(0, 99) < 75) begin
            if (held_blocks.size() != 0
                && $urandom_range(0, 99) < 40 + 4 * held_blocks.size()) begin
                // give back an owned block, size restated within its class
                k   = $urandom_range(0, held_blocks.size() - 1);
                blk = held_blocks[k];
                held_blocks.delete(k);
                row.act  = ACT_FREE;
                row.offs = blk.offs;
                row.bytes = $urandom_range(0, 1) ? blk.bytes
                                                 : bytes_in_level(size_level(blk.bytes));
                recent_frees.push_back(blk);
                if (recent_frees.size() > 4) void'(recent_frees.pop_front());
            end else begin
                // small sizes dominate so the pool splits deep
                lv = $urandom_range(0, 1) ? $urandom_range(0, pool_top)
                                          : $urandom_range(0, (pool_top < 2) ? pool_top : 2);
                row.act   = ACT_ALLOC;
                row.bytes = bytes_in_level(lv);
            end
        end else begin
            lv = $urandom_range(0, pool_top);
            case ($urandom_range(0, 3))
                0: begin
                    // anything at all
                    row.act   = 1'($urandom);
                    row.bytes = REQ_W'($urandom);
                end
                1: begin
                    // free off its block boundary by half a block
                    row.act   = ACT_FREE;
                    row.bytes = bytes_in_level(lv);
                    row.offs  = REQ_W'($urandom_range(0, pool - 1)) | REQ_W'(MIN_B / 2 << lv);
                end
                2: begin
                    if (recent_frees.size() != 0) begin
                        // same block given back twice
                        blk = recent_frees[$urandom_range(0, recent_frees.size() - 1)];
                        row.act   = ACT_FREE;
                        row.offs  = blk.offs;
                        row.bytes = blk.bytes;
                    end else begin
                        // past the end of the pool
                        row.act   = ACT_FREE;
                        row.bytes = bytes_in_level(lv);
                        row.offs  = REQ_W'($urandom_range(pool, (1 << REQ_W) - 1));
                    end
                end
                default: begin
                    // bigger than the pool
                    row.act   = 1'($urandom);
                    row.bytes = REQ_W'($urandom_range(pool + 1, (1 << REQ_W) - 1));
                end
            endcase
        end
    endtask

    // response side: mostly ready, short and long stalls, runs with no stall,
    // and one long hold-off when the request side asks for it
    initial begin
        int unsigned r;
        rsp_bus.ready <= 1'b0;
        forever begin
            if (hold_rsp) begin
                hold_rsp = 1'b0;
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_CYC) @(posedge clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    rsp_bus.ready <= 1'b1;
                    @(posedge clk);
                end else if (r < 85) begin
                    rsp_bus.ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end else if (r < 88) begin
                    rsp_bus.ready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge clk);
                end else begin
                    rsp_bus.ready <= 1'b1;
                    repeat ($urandom_range(20, 60)) @(posedge clk);
                end
            end
        end
    end

    // every response beat against the oldest owed answer
    always @(posedge clk) begin
        t_answer ans;
        if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (alloc_answers.size() == 0) begin
                flag_mismatch($sformatf("response with none owed: offset %0d status %0d",
                                        rsp_bus.granted_offset, rsp_bus.status));
            end else begin
                ans = alloc_answers.pop_front();
                if (rsp_bus.granted_offset !== ans.grant)
                    flag_mismatch($sformatf("granted_offset %0d, want %0d",
                                            rsp_bus.granted_offset, ans.grant));
                if (rsp_bus.status !== ans.status)
                    flag_mismatch($sformatf("status %0d, want %0d",
                                            rsp_bus.status, ans.status));
            end
        end
    end

    // hard stop well beyond the slowest correct run
    initial begin
        #20_000_000;
        $display("buddy_block_allocator_unit regression: fail");
        $finish;
    end

    // request side: directed rows, then random traffic under several pool sizes
    initial begin
        logic [TOP_W-1:0] tops [6];
        t_row             row;
        bit               no_gaps;
        tops = '{4'd0, 4'd3, 4'd15, 4'd1, 4'd6, 4'd8};
        mismatches = 0;
        hold_rsp   = 1'b0;
        no_gaps    = 1'b0;
        rst_n                 <= 1'b0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.top_level     <= '0;
        req_bus.valid         <= 1'b0;
        req_bus.action        <= ACT_ALLOC;
        req_bus.request_bytes <= '0;
        req_bus.block_offset  <= '0;
        pool_init(TOP_RESET);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PLAN[i]) begin
            offer_req(PLAN[i]);
            req_gap(gap_len());
        end

        // six top_level settings, the smallest, the largest and an out of range one among them
        foreach (tops[p]) begin
            write_top(tops[p]);
            for (int i = 0; i < RAND_ITEMS; i++) begin
                if (i % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
                // block fills up behind a long response hold-off
                if (p == 2 && i == 20) hold_rsp = 1'b1;
                // one pause until everything owed has come back
                if (p == 1 && i == 100) begin
                    req_bus.valid <= 1'b0;
                    drain_answers();
                end
                pick_req(row);
                offer_req(row);
                if (!no_gaps) req_gap(gap_len());
            end
        end

        req_bus.valid <= 1'b0;
        drain_answers();
        repeat (SETTLE_CYC) @(posedge clk);
        if (mismatches == 0) begin
            $display("buddy_block_allocator_unit regression: pass");
        end else begin
            $display("buddy_block_allocator_unit regression: fail");
        end
        $finish;
    end

endmodule

// ----- buddy_block_allocator_unit.f -----
rtl/core/bba_pkg.sv
rtl/core/bba_ifs.sv
rtl/core/bba_ctrl.sv
rtl/core/bba_dpath.sv
rtl/core/buddy_block_allocator_unit.sv
tb/tb.sv
